// ===== sv/date_add_days_unit_macros.svh =====
// assertion macros shared by the date add days unit
`ifndef DATE_ADD_DAYS_UNIT_MACROS_SVH
`define DATE_ADD_DAYS_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define DAU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("date add days unit: assertion failed");
`define DAU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("date add days unit: assertion failed");
`else
`define DAU_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DAU_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/dau_pkg.sv =====
// types, constants, microcode rom and calendar helpers of the date add days unit
package dau_pkg;

  localparam int unsigned DayInW     = 6;
  localparam int unsigned MonthW     = 4;
  localparam int unsigned YearW      = 16;
  localparam int unsigned AddW       = 16;
  localparam int unsigned DayOutW    = 5;
  localparam int unsigned DaySumW    = AddW + 1;
  localparam int unsigned LenW       = 5;
  localparam int unsigned RemW       = 7;
  localparam int unsigned RecipW     = 13;
  localparam int unsigned ProdW      = YearW + RecipW;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned QuotW      = ProdW - RecipShift;
  localparam int unsigned DivCntW    = 1;
  localparam int unsigned UpcW       = 3;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthApr = 4'd4;
  localparam logic [MonthW-1:0] MonthJun = 4'd6;
  localparam logic [MonthW-1:0] MonthSep = 4'd9;
  localparam logic [MonthW-1:0] MonthNov = 4'd11;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  localparam logic [LenW-1:0] LenLong  = 5'd31;
  localparam logic [LenW-1:0] LenShort = 5'd30;
  localparam logic [LenW-1:0] LenFeb   = 5'd28;
  localparam logic [LenW-1:0] LenFebLp = 5'd29;

  localparam logic [RemW:0]      CenturyDiv = 8'd100;
  localparam logic [RemW-1:0]    RemLast    = 7'd99;
  // ceil(2^19 / 100), exact quotient for every year up to 43690
  localparam logic [RecipW-1:0]  RecipCent  = 13'd5243;
  localparam logic [DivCntW-1:0] DivLast    = 1'b1;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_DIV,
    OP_CHECK,
    OP_WALK,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_IN_VALID,
    COND_DIV_LAST,
    COND_DATE_OK,
    COND_DAY_FITS,
    COND_OUT_FREE
  } cond_e;

  typedef logic [UpcW-1:0] upc_t;

  localparam upc_t UpcIdle  = 3'd0;
  localparam upc_t UpcDiv   = 3'd1;
  localparam upc_t UpcCheck = 3'd2;
  localparam upc_t UpcWalk  = 3'd3;
  localparam upc_t UpcEmit  = 3'd4;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_t  tgt_true;
    upc_t  tgt_false;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic div_last;
    logic date_ok;
    logic day_fits;
    logic out_free;
  } status_t;

  // control store: one word per step
  function automatic ucode_t ucode_rom(upc_t upc);
    ucode_t w;
    unique case (upc)
      UpcIdle:  w = '{op: OP_LOAD,  cond: COND_IN_VALID, tgt_true: UpcDiv,   tgt_false: UpcIdle};
      UpcDiv:   w = '{op: OP_DIV,   cond: COND_DIV_LAST, tgt_true: UpcCheck, tgt_false: UpcDiv};
      UpcCheck: w = '{op: OP_CHECK, cond: COND_DATE_OK,  tgt_true: UpcWalk,  tgt_false: UpcEmit};
      UpcWalk:  w = '{op: OP_WALK,  cond: COND_DAY_FITS, tgt_true: UpcEmit,  tgt_false: UpcWalk};
      UpcEmit:  w = '{op: OP_EMIT,  cond: COND_OUT_FREE, tgt_true: UpcIdle,  tgt_false: UpcEmit};
      default:  w = '{op: OP_LOAD,  cond: COND_IN_VALID, tgt_true: UpcDiv,   tgt_false: UpcIdle};
    endcase
    return w;
  endfunction

  function automatic logic [LenW-1:0] month_len(logic [MonthW-1:0] month, logic leap);
    logic [LenW-1:0] len;
    unique case (month)
      MonthFeb:                               len = leap ? LenFebLp : LenFeb;
      MonthApr, MonthJun, MonthSep, MonthNov: len = LenShort;
      default:                                len = LenLong;
    endcase
    return len;
  endfunction

endpackage

// ===== sv/dau_in_if.sv =====
// input channel of the date add days unit: start date and day count
interface dau_in_if;
  logic                             valid;
  logic                             ready;
  logic        [dau_pkg::DayInW-1:0] day_in;
  logic        [dau_pkg::MonthW-1:0] month_in;
  logic signed [dau_pkg::YearW-1:0]  year_in;
  logic        [dau_pkg::AddW-1:0]   days_to_add;

  modport source (output valid, day_in, month_in, year_in, days_to_add, input ready);
  modport sink   (input valid, day_in, month_in, year_in, days_to_add, output ready);
endinterface

// ===== sv/dau_out_if.sv =====
// output channel of the date add days unit: resulting date and valid flag
interface dau_out_if;
  logic                              valid;
  logic                              ready;
  logic                              date_valid;
  logic [dau_pkg::DayOutW-1:0]       day_out;
  logic [dau_pkg::MonthW-1:0]        month_out;
  logic [dau_pkg::YearW-1:0]         year_out;

  modport source (output valid, date_valid, day_out, month_out, year_out, input ready);
  modport sink   (input valid, date_valid, day_out, month_out, year_out, output ready);
endinterface

// ===== sv/dau_useq.sv =====
// microcode sequencer: step counter, control store and conditional jumps
`include "date_add_days_unit_macros.svh"

module dau_useq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dau_pkg::status_t  status_i,
  output dau_pkg::op_e      op_o
);

  dau_pkg::upc_t   upc_q, upc_d;
  dau_pkg::ucode_t word;
  logic            cond_hit;

  assign word = dau_pkg::ucode_rom(upc_q);
  assign op_o = word.op;

  always_comb begin
    unique case (word.cond)
      dau_pkg::COND_IN_VALID: cond_hit = status_i.in_valid;
      dau_pkg::COND_DIV_LAST: cond_hit = status_i.div_last;
      dau_pkg::COND_DATE_OK:  cond_hit = status_i.date_ok;
      dau_pkg::COND_DAY_FITS: cond_hit = status_i.day_fits;
      dau_pkg::COND_OUT_FREE: cond_hit = status_i.out_free;
      default:                cond_hit = 1'b0;
    endcase
    upc_d = cond_hit ? word.tgt_true : word.tgt_false;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= dau_pkg::UpcIdle;
    end else begin
      upc_q <= upc_d;
    end
  end

  `DAU_ASSERT_NXT(a_accept_starts_div, clk_i, rst_ni, upc_q == dau_pkg::UpcIdle && status_i.in_valid, upc_q == dau_pkg::UpcDiv)
  `DAU_ASSERT_NXT(a_div_runs_on, clk_i, rst_ni, upc_q == dau_pkg::UpcDiv && !status_i.div_last, upc_q == dau_pkg::UpcDiv)
  `DAU_ASSERT_IMP(a_upc_in_program, clk_i, rst_ni, 1'b1, upc_q <= dau_pkg::UpcEmit)

endmodule

// ===== sv/dau_dp.sv =====
// datapath: date registers, year / 100 by reciprocal, month walk and output register
`include "date_add_days_unit_macros.svh"

module dau_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dau_pkg::op_e      op_i,
  output dau_pkg::status_t  status_o,
  dau_in_if.sink            in_i,
  dau_out_if.source         out_o
);

  logic [dau_pkg::DayInW-1:0]  d_q, d_d;
  logic [dau_pkg::DaySumW-1:0] day_q, day_d;
  logic [dau_pkg::MonthW-1:0]  month_q, month_d;
  logic [dau_pkg::YearW-1:0]   year_q, year_d;
  logic [dau_pkg::RemW-1:0]    rem_q, rem_d;
  logic [dau_pkg::QuotW-1:0]   quot_q, quot_d;
  logic [dau_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                        ok_q, ok_d;

  logic                        out_valid_q, out_valid_d;
  logic                        out_ok_q;
  logic [dau_pkg::DayOutW-1:0] out_day_q;
  logic [dau_pkg::MonthW-1:0]  out_month_q;
  logic [dau_pkg::YearW-1:0]   out_year_q;

  logic                        leap;
  logic [dau_pkg::LenW-1:0]    len;
  logic [dau_pkg::ProdW-1:0]   prod;
  logic [dau_pkg::YearW-1:0]   cent;
  logic                        date_ok;
  logic                        day_fits;
  logic                        in_fire;
  logic                        out_free;
  logic                        out_load;

  // year mod 100 and (year / 100) mod 4 decide the leap rule
  assign leap  = (rem_q == '0) ? (quot_q[1:0] == 2'b00) : (rem_q[1:0] == 2'b00);
  assign len   = dau_pkg::month_len(month_q, leap);
  assign prod  = dau_pkg::ProdW'(year_q) * dau_pkg::ProdW'(dau_pkg::RecipCent);
  assign cent  = dau_pkg::YearW'(quot_q) * dau_pkg::YearW'(dau_pkg::CenturyDiv);

  assign date_ok  = !year_q[dau_pkg::YearW-1]
                  && (month_q >= dau_pkg::MonthJan) && (month_q <= dau_pkg::MonthDec)
                  && (d_q != '0) && (d_q <= dau_pkg::DayInW'(len));
  assign day_fits = (day_q <= dau_pkg::DaySumW'(len));

  assign in_i.ready = (op_i == dau_pkg::OP_LOAD);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign out_load   = (op_i == dau_pkg::OP_EMIT) && out_free;

  assign status_o = '{in_valid: in_i.valid, div_last: (cnt_q == dau_pkg::DivLast),
                      date_ok: date_ok, day_fits: day_fits, out_free: out_free};

  always_comb begin
    d_d      = d_q;
    day_d    = day_q;
    month_d  = month_q;
    year_d   = year_q;
    rem_d    = rem_q;
    quot_d   = quot_q;
    cnt_d    = cnt_q;
    ok_d     = ok_q;
    unique case (op_i)
      dau_pkg::OP_LOAD: begin
        if (in_fire) begin
          d_d      = in_i.day_in;
          day_d    = dau_pkg::DaySumW'(in_i.day_in) + dau_pkg::DaySumW'(in_i.days_to_add);
          month_d  = in_i.month_in;
          year_d   = $unsigned(in_i.year_in);
          rem_d    = '0;
          quot_d   = '0;
          cnt_d    = '0;
        end
      end
      dau_pkg::OP_DIV: begin
        // first step: quotient by reciprocal multiply, second step: remainder
        quot_d = prod[dau_pkg::ProdW-1:dau_pkg::RecipShift];
        rem_d  = dau_pkg::RemW'(year_q - cent);
        cnt_d  = cnt_q + 1'b1;
      end
      dau_pkg::OP_CHECK: begin
        ok_d = date_ok;
      end
      dau_pkg::OP_WALK: begin
        if (!day_fits) begin
          day_d = day_q - dau_pkg::DaySumW'(len);
          if (month_q == dau_pkg::MonthDec) begin
            month_d = dau_pkg::MonthJan;
            year_d  = year_q + 1'b1;
            if (rem_q == dau_pkg::RemLast) begin
              rem_d  = '0;
              quot_d = quot_q + 1'b1;
            end else begin
              rem_d = rem_q + 1'b1;
            end
          end else begin
            month_d = month_q + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    d_q      <= d_d;
    day_q    <= day_d;
    month_q  <= month_d;
    year_q   <= year_d;
    rem_q    <= rem_d;
    quot_q   <= quot_d;
    cnt_q    <= cnt_d;
    ok_q     <= ok_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ok_q    <= ok_q;
      out_day_q   <= ok_q ? day_q[dau_pkg::DayOutW-1:0] : '0;
      out_month_q <= ok_q ? month_q : '0;
      out_year_q  <= ok_q ? year_q : '0;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.date_valid = out_ok_q;
  assign out_o.day_out    = out_day_q;
  assign out_o.month_out  = out_month_q;
  assign out_o.year_out   = out_year_q;

  `DAU_ASSERT_IMP(a_rem_in_range, clk_i, rst_ni, op_i == dau_pkg::OP_WALK, rem_q <= dau_pkg::RemLast)
  `DAU_ASSERT_NXT(a_walk_shrinks_day, clk_i, rst_ni, op_i == dau_pkg::OP_WALK && !day_fits, day_q < $past(day_q))
  `DAU_ASSERT_IMP(a_invalid_gives_zero, clk_i, rst_ni, out_valid_q && !out_ok_q, out_day_q == '0 && out_month_q == '0 && out_year_q == '0)

endmodule

// ===== sv/date_add_days_unit.sv =====
// top level of the date add days unit: sequencer plus datapath
// a valid date goes through load, the divide steps, the date check, the month walk until
// the day fits (up to about 2160 months crossed for the largest day count) and the emit step;
// an invalid date skips the walk; one item at a time, the next is taken after its emit step
// a new input beat is taken while a finished result still waits in the output register
// reset: asynchronous active low, clears the step counter and the output valid flag
module date_add_days_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  dau_in_if.sink     in_i,
  dau_out_if.source  out_o
);

  // condition flags from the datapath to the sequencer
  dau_pkg::status_t status;
  // datapath operation selected by the current control word
  dau_pkg::op_e     op;

  // program: load, 2 divide steps (reciprocal multiply for year / 100, then the
  // remainder), date check, month walk until the day fits (skipped for an invalid
  // date), then hand the result to the output register
  dau_useq u_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .op_o     (op)
  );

  // datapath owns the input ready (only in the load step) and the output beat
  dau_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (op),
    .status_o (status),
    .in_i     (in_i),
    .out_o    (out_o)
  );

endmodule

// ===== bench/date_add_days_unit_tb.sv =====
// self-checking testbench of the date add days unit
`timescale 1ns / 1ps

module date_add_days_unit_tb;

  // cycles without any beat before the run is declared hung; the slowest item
  // walks about 2200 months, and the receiver also holds off for HoldCycles
  localparam int unsigned IdleLimit  = 12000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned TailCycles = 40;
  localparam int unsigned MaxLines   = 40;

  typedef struct packed {
    logic                         date_valid;
    logic [dau_pkg::DayOutW-1:0]  day;
    logic [dau_pkg::MonthW-1:0]   month;
    logic [dau_pkg::YearW-1:0]    year;
  } date_res_t;

  logic clk;
  logic rst_n;

  dau_in_if  in_ch ();
  dau_out_if out_ch ();

  date_add_days_unit DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // resulting dates still owed by the block, oldest first
  date_res_t   pending_dates[$];
  int unsigned mismatches;
  date_res_t   oldest_date;

  // knobs shared between the test tasks and the receiver process
  bit no_idle;
  bit hold_req;
  bit hold_active;

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // calendar predictor
  // ---------------------------------------------------------------------------

  function automatic bit leap_year(int unsigned y);
    if (y % 400 == 0) return 1'b1;
    if (y % 100 == 0) return 1'b0;
    return (y % 4) == 0;
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    if (m == dau_pkg::MonthFeb) return leap_year(y) ? 29 : 28;
    if (m == dau_pkg::MonthApr || m == dau_pkg::MonthJun || m == dau_pkg::MonthSep
        || m == dau_pkg::MonthNov) return 30;
    return 31;
  endfunction

  // start date plus a day count; all zero when the start date is not a date
  function automatic date_res_t advance_date(logic [dau_pkg::DayInW-1:0] d,
                                             logic [dau_pkg::MonthW-1:0] m,
                                             logic [dau_pkg::YearW-1:0] y,
                                             logic [dau_pkg::AddW-1:0] add);
    date_res_t   res;
    int unsigned day;
    int unsigned mon;
    int unsigned yr;
    int unsigned len;
    res = '0;
    // negative year or month out of 1..12
    if (y[dau_pkg::YearW-1] || m < dau_pkg::MonthJan || m > dau_pkg::MonthDec) return res;
    mon = m;
    yr  = y;
    // day zero or past the end of its month, feb 29 only in leap years
    if (d == 0 || d > days_in_month(mon, yr)) return res;
    day = d + add;
    len = days_in_month(mon, yr);
    // walk month by month until the day fits, december carries into the year
    while (day > len) begin
      day -= len;
      if (mon == dau_pkg::MonthDec) begin
        mon = dau_pkg::MonthJan;
        yr  = yr + 1;
      end else begin
        mon = mon + 1;
      end
      len = days_in_month(mon, yr);
    end
    res.date_valid = 1'b1;
    res.day        = dau_pkg::DayOutW'(day);
    res.month      = dau_pkg::MonthW'(mon);
    res.year       = dau_pkg::YearW'(yr);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // shared helpers
  // ---------------------------------------------------------------------------

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= MaxLines)
      $display("%0t ns  %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // one input beat; called at a rising edge, returns at the edge of acceptance
  // with valid still high, or after the idle gap with valid low if a gap follows
  task automatic send_date(logic [dau_pkg::DayInW-1:0] d, logic [dau_pkg::MonthW-1:0] m,
                           logic signed [dau_pkg::YearW-1:0] y,
                           logic [dau_pkg::AddW-1:0] add);
    int unsigned gap;
    in_ch.valid       <= 1'b1;
    in_ch.day_in      <= d;
    in_ch.month_in    <= m;
    in_ch.year_in     <= y;
    in_ch.days_to_add <= add;
    do @(posedge clk); while (!in_ch.ready);
    pending_dates.push_back(advance_date(d, m, y, add));
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender pauses until every owed result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_dates.size() != 0);
  endtask

  // year picker biased toward century years and the top of the range
  function automatic logic [dau_pkg::YearW-1:0] pick_year();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return dau_pkg::YearW'($urandom_range(0, 32767));
    if (sel < 7)
      return dau_pkg::YearW'($urandom_range(0, 327) * 100 + $urandom_range(0, 4));
    if (sel < 9) return dau_pkg::YearW'(32767 - $urandom_range(0, 400));
    return dau_pkg::YearW'($urandom_range(1890, 2110));
  endfunction

  // mostly a valid date, often the last day of its month, sometimes one past it
  task automatic send_random_date();
    logic [dau_pkg::YearW-1:0]  y;
    logic [dau_pkg::MonthW-1:0] m;
    logic [dau_pkg::DayInW-1:0] d;
    logic [dau_pkg::AddW-1:0]   add;
    int unsigned                len;
    int unsigned                sel;
    y   = pick_year();
    m   = dau_pkg::MonthW'($urandom_range(dau_pkg::MonthJan, dau_pkg::MonthDec));
    len = days_in_month(m, y);
    sel = $urandom_range(0, 9);
    if (sel < 3) d = dau_pkg::DayInW'(len);
    else if (sel == 3) d = dau_pkg::DayInW'(len + 1);
    else d = dau_pkg::DayInW'($urandom_range(1, len));
    // day counts mostly small so the month walk stays short
    sel = $urandom_range(0, 19);
    if (sel < 11) add = dau_pkg::AddW'($urandom_range(0, 400));
    else if (sel < 16) add = dau_pkg::AddW'($urandom_range(0, 4000));
    else add = dau_pkg::AddW'($urandom);
    send_date(d, m, y, add);
  endtask

  // ---------------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------------

  task automatic test_directed_dates();
    // field extremes and year carry
    send_date(6'd1,  dau_pkg::MonthJan, 16'sd0,     16'd0);
    send_date(6'd31, dau_pkg::MonthDec, 16'sd32767, 16'd65535);
    send_date(6'd31, dau_pkg::MonthDec, 16'sd32767, 16'd1);
    send_date(6'd1,  dau_pkg::MonthJan, 16'sd0,     16'd65535);
    send_date(6'd31, dau_pkg::MonthJan, 16'sd2023,  16'd65535);
    // leap february, kept day 29 and the century rules
    send_date(6'd28, dau_pkg::MonthFeb, 16'sd2024,  16'd1);
    send_date(6'd29, dau_pkg::MonthFeb, 16'sd2024,  16'd0);
    send_date(6'd29, dau_pkg::MonthFeb, 16'sd2000,  16'd1);
    send_date(6'd28, dau_pkg::MonthFeb, 16'sd1900,  16'd1);
    send_date(6'd29, dau_pkg::MonthFeb, 16'sd2023,  16'd0);
    send_date(6'd29, dau_pkg::MonthFeb, 16'sd1900,  16'd0);
    // month ends, just inside and just past
    send_date(6'd30, dau_pkg::MonthApr, 16'sd2021,  16'd1);
    send_date(6'd31, dau_pkg::MonthApr, 16'sd2021,  16'd0);
    send_date(6'd32, dau_pkg::MonthJan, 16'sd2021,  16'd0);
    // malformed day, month and year
    send_date(6'd0,  dau_pkg::MonthJan, 16'sd2021,  16'd5);
    send_date(6'd63, 4'd15,             16'sd2021,  16'd5);
    send_date(6'd10, 4'd0,              16'sd2021,  16'd5);
    send_date(6'd10, 4'd13,             16'sd2021,  16'd5);
    send_date(6'd10, dau_pkg::MonthJun, -16'sd1,    16'd5);
    send_date(6'd1,  dau_pkg::MonthJan, -16'sd32768, 16'd0);
    drain_results();
  endtask

  task automatic test_random_dates(int unsigned count);
    repeat (count) send_random_date();
  endtask

  // arbitrary bit patterns, mostly rejected dates
  task automatic test_random_noise(int unsigned count);
    repeat (count)
      send_date(dau_pkg::DayInW'($urandom), dau_pkg::MonthW'($urandom),
                dau_pkg::YearW'($urandom), dau_pkg::AddW'($urandom));
  endtask

  // receiver stops for a long stretch while items keep coming, so the output
  // register fills and the input stalls
  task automatic test_output_backpressure(int unsigned count);
    hold_req = 1'b1;
    do @(posedge clk); while (!hold_active);
    no_idle = 1'b1;
    repeat (count)
      send_date(dau_pkg::DayInW'($urandom_range(1, 28)),
                dau_pkg::MonthW'($urandom_range(dau_pkg::MonthJan, dau_pkg::MonthDec)),
                dau_pkg::YearW'($urandom_range(0, 32767)),
                dau_pkg::AddW'($urandom_range(0, 200)));
    no_idle = 1'b0;
    drain_results();
  endtask

  // short bursts, each followed by a full drain
  task automatic test_drain_pauses(int unsigned bursts);
    repeat (bursts) begin
      repeat ($urandom_range(1, 3)) send_random_date();
      drain_results();
    end
  endtask

  // back to back traffic with both sides always ready
  task automatic test_no_idle(int unsigned count);
    no_idle = 1'b1;
    repeat (count) send_random_date();
    drain_results();
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // receiver ready and result checking
  // ---------------------------------------------------------------------------

  initial begin : result_ready
    int unsigned n;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        // long hold-off counted here, not by the sender
        out_ch.ready <= 1'b0;
        hold_active = 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_active = 1'b0;
        hold_req    = 1'b0;
      end else if (no_idle) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // every result beat against the oldest owed date
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("result with nothing owed, date_valid", out_ch.date_valid, 0);
      end else begin
        oldest_date = pending_dates.pop_front();
        if (out_ch.date_valid !== oldest_date.date_valid)
          report_mismatch("date_valid", out_ch.date_valid, oldest_date.date_valid);
        if (out_ch.day_out !== oldest_date.day)
          report_mismatch("day_out", out_ch.day_out, oldest_date.day);
        if (out_ch.month_out !== oldest_date.month)
          report_mismatch("month_out", out_ch.month_out, oldest_date.month);
        if (out_ch.year_out !== oldest_date.year)
          report_mismatch("year_out", out_ch.year_out, oldest_date.year);
      end
    end
  end

  // hang detection: cycles in a row with no beat on either side
  initial begin : hang_watch
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("date_add_days_unit: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    mismatches        = 0;
    no_idle           = 1'b0;
    hold_req          = 1'b0;
    hold_active       = 1'b0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.day_in      = '0;
    in_ch.month_in    = '0;
    in_ch.year_in     = '0;
    in_ch.days_to_add = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_dates();
    test_random_dates(170);
    test_random_noise(40);
    test_output_backpressure(12);
    test_drain_pauses(4);
    test_no_idle(25);

    // late or spurious results get a tail of TailCycles to show up
    drain_results();
    repeat (TailCycles) @(posedge clk);
    if (pending_dates.size() != 0)
      report_mismatch("results still owed", 0, pending_dates.size());

    if (mismatches == 0) begin
      $display("date_add_days_unit: match");
    end else begin
      $display("date_add_days_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/dau_pkg.sv
sv/dau_in_if.sv
sv/dau_out_if.sv
sv/dau_useq.sv
sv/dau_dp.sv
sv/date_add_days_unit.sv
bench/date_add_days_unit_tb.sv
